// ===== rtl/adler32_pkg.sv =====
// Shared types and constants for the Adler-32 checksum unit.
// No dependencies; imported by all RTL files but adler32_out_if.
`default_nettype none

package adler32_pkg;

    // Adler-32 modulus and the fixed geometry of one input word
    localparam int unsigned ADLER_MOD     = 65521;
    localparam int unsigned WORD_BYTES    = 4;
    localparam int unsigned DEFAULT_LANES = 4;

    localparam int unsigned COUNT_W = 3;   // byte_count width
    localparam int unsigned SUM_W   = 16;  // width of each running sum
    localparam int unsigned BSUM_W  = 10;  // sum of up to four bytes
    localparam int unsigned WSUM_W  = 12;  // weighted sum, weights up to four
    localparam int unsigned WTERM_W = 10;  // one byte times a weight up to four

    localparam logic [SUM_W:0] MOD_VAL = 17'(ADLER_MOD);

    // Contribution of one byte lane
    typedef struct packed {
        logic [7:0]         byte_term;  // byte if valid, else zero
        logic [WTERM_W-1:0] wtd_term;   // byte times its remaining-bytes weight
    } lane_term_t;

    // Merged word summary handed to the accumulator
    typedef struct packed {
        logic [BSUM_W-1:0]  byte_sum;
        logic [WSUM_W-1:0]  wtd_sum;
        logic [COUNT_W-1:0] count;
        logic               last;
    } word_sum_t;

endpackage

`default_nettype wire

// ===== rtl/adler32_in_if.sv =====
// Input channel of the Adler-32 unit: valid/ready plus one word of message bytes.
// Depends on adler32_pkg for the byte count width.
`default_nettype none

interface adler32_in_if
    import adler32_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [31:0]        data_bytes;
    logic [COUNT_W-1:0] byte_count;
    logic               last;

    modport source (output valid, output data_bytes, output byte_count, output last,
                    input ready);
    modport sink   (input valid, input data_bytes, input byte_count, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/adler32_out_if.sv =====
// Output channel of the Adler-32 unit: valid/ready plus the 32-bit digest.
// No dependencies.
`default_nettype none

interface adler32_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest;

    modport source (output valid, output digest, input ready);
    modport sink   (input valid, input digest, output ready);
endinterface

`default_nettype wire

// ===== rtl/adler32_lane.sv =====
// One byte lane: masks its byte by the valid count and weights it by the
// number of bytes from it to the end of the word. Depends on adler32_pkg.
`default_nettype none

module adler32_lane
    import adler32_pkg::*;
#(
    parameter int unsigned IDX = 0
) (
    input  wire logic [7:0]         byte_val,
    input  wire logic [COUNT_W-1:0] count,
    output lane_term_t              term
);

    localparam logic [COUNT_W-1:0] IDX_K = COUNT_W'(IDX);

    logic               active;
    logic [COUNT_W-1:0] weight;

    // byte IDX is valid when count exceeds its position
    assign active = (count > IDX_K);
    assign weight = count - IDX_K;

    always_comb
    begin
        if (active)
        begin
            term.byte_term = byte_val;
            term.wtd_term  = WTERM_W'(byte_val) * WTERM_W'(weight);
        end
        else
        begin
            term.byte_term = '0;
            term.wtd_term  = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adler32_merge.sv =====
// Merge stage: adds the lane terms into a plain byte sum and a weighted sum.
// Depends on adler32_pkg.
`default_nettype none

module adler32_merge
    import adler32_pkg::*;
#(
    parameter int unsigned N = DEFAULT_LANES
) (
    input  wire lane_term_t [N-1:0] terms,
    output logic [BSUM_W-1:0]       byte_sum,
    output logic [WSUM_W-1:0]       wtd_sum
);

    // independent adds over at most four lanes
    always_comb
    begin
        byte_sum = '0;
        wtd_sum  = '0;
        for (int i = 0; i < N; i++)
        begin
            byte_sum = byte_sum + BSUM_W'(terms[i].byte_term);
            wtd_sum  = wtd_sum + WSUM_W'(terms[i].wtd_term);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adler32_accum.sv =====
// Running-sum accumulator: folds one merged word into the low and high sums
// modulo 65521, holds the start value and the digest output register.
// Depends on adler32_pkg.
`default_nettype none

module adler32_accum
    import adler32_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [SUM_W-1:0] cfg_wr_data,
    input  wire logic             word_valid,
    input  wire word_sum_t        word,
    output logic                  word_ready,
    adler32_out_if.source         result
);

    localparam int unsigned HX_W = 20;

    logic [SUM_W-1:0] start_reg;
    logic [SUM_W-1:0] low_reg,  low_next;
    logic [SUM_W-1:0] high_reg, high_next;
    logic             out_valid_reg;
    logic [31:0]      digest_reg;

    logic             word_fire;
    logic [SUM_W:0]   low_raw;
    logic [HX_W-1:0]  high_raw;
    logic [SUM_W:0]   high_fold;

    // a last word needs the output register free or draining
    assign word_ready = !word.last || !out_valid_reg || result.ready;
    assign word_fire  = word_valid && word_ready;

    // low: one add and a single conditional subtract (sum stays below 2*mod)
    assign low_raw = 17'(low_reg) + 17'(word.byte_sum);

    // high: H + k*L + weighted sum, then fold 2^16 == 15 (mod 65521)
    assign high_raw  = HX_W'(high_reg) + HX_W'(20'(word.count) * 20'(low_reg))
                       + HX_W'(word.wtd_sum);
    assign high_fold = 17'(high_raw[SUM_W-1:0])
                       + 17'(high_raw[HX_W-1:SUM_W]) * 17'd15;

    always_comb
    begin
        if (word.count == '0)
        begin
            low_next = low_reg;
        end
        else if (low_raw >= MOD_VAL)
        begin
            low_next = SUM_W'(low_raw - MOD_VAL);
        end
        else
        begin
            low_next = low_raw[SUM_W-1:0];
        end

        if (high_fold >= MOD_VAL)
        begin
            high_next = SUM_W'(high_fold - MOD_VAL);
        end
        else
        begin
            high_next = high_fold[SUM_W-1:0];
        end
    end

    // start value register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 16'd1;
        end
        else if (cfg_wr_en)
        begin
            start_reg <= cfg_wr_data;
        end
    end

    // running sums and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= 16'd1;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new digest wins over the drain of the old one
            if (word_fire && word.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (word_fire)
            begin
                if (word.last)
                begin
                    low_reg  <= start_reg;
                    high_reg <= '0;
                end
                else
                begin
                    low_reg  <= low_next;
                    high_reg <= high_next;
                end
            end
        end
    end

    // digest payload
    always_ff @(posedge clk)
    begin
        if (word_fire && word.last)
        begin
            digest_reg <= {high_next, low_next};
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.digest = digest_reg;

endmodule

`default_nettype wire

// ===== rtl/adler32_checksum_unit.sv =====
// Adler-32 checksum unit: byte lanes, merge stage and accumulator.
// Streams words of up to four message bytes (lowest byte first) on 'stream'.
// A word flagged last closes the message; its 32-bit digest (high sum in
// bits 31..16, low sum in bits 15..0) leaves on 'result'.
// Throughput: one word per cycle unless stalled. Per word, the byte lanes
// and merge stage feed a stage register; the accumulator then folds the whole
// word into both sums in one step (low += byte sum, high += k*low + weighted
// byte sum). result.valid rises once the accumulator takes the last word.
// cfg_wr_en/cfg_wr_data load the start value of the low sum, taken when the
// next last word is accepted; write it while no transaction is in flight.
// Reset: start value 1, low sum 1, high sum 0, both stages empty.
// Stall: while a digest waits, non-last words keep flowing, and one last word
// can wait in the stage register; only then does stream.ready drop.
// Depends on adler32_pkg, adler32_in_if, adler32_out_if and the submodules.
`default_nettype none

module adler32_checksum_unit
    import adler32_pkg::*;
#(
    parameter int unsigned LANES = DEFAULT_LANES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    adler32_in_if.sink       stream,
    adler32_out_if.source    result
);

    // lanes that can hold a byte of the four-byte word
    localparam int unsigned ACT = (LANES < WORD_BYTES) ? LANES : WORD_BYTES;
    localparam logic [COUNT_W-1:0] ACT_K = COUNT_W'(ACT);

    logic [COUNT_W-1:0]   count_clamped;
    lane_term_t [ACT-1:0] terms;
    logic [BSUM_W-1:0]    byte_sum;
    logic [WSUM_W-1:0]    wtd_sum;

    logic                 stage_valid_reg;
    word_sum_t            stage_reg;
    logic                 acc_ready;
    logic                 in_fire;

    // limit the count to the lanes present
    assign count_clamped = (stream.byte_count > ACT_K) ? ACT_K : stream.byte_count;

    // byte lanes
    for (genvar i = 0; i < ACT; i++)
    begin : g_lane
        adler32_lane #(
            .IDX (i)
        ) u_lane (
            .byte_val (stream.data_bytes[8*i +: 8]),
            .count    (count_clamped),
            .term     (terms[i])
        );
    end

    adler32_merge #(
        .N (ACT)
    ) u_merge (
        .terms    (terms),
        .byte_sum (byte_sum),
        .wtd_sum  (wtd_sum)
    );

    // stage register between merge and accumulator
    assign stream.ready = !stage_valid_reg || acc_ready;
    assign in_fire      = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            stage_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_reg.byte_sum <= byte_sum;
            stage_reg.wtd_sum  <= wtd_sum;
            stage_reg.count    <= count_clamped;
            stage_reg.last     <= stream.last;
        end
    end

    adler32_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .word_valid  (stage_valid_reg),
        .word        (stage_reg),
        .word_ready  (acc_ready),
        .result      (result)
    );

endmodule

`default_nettype wire

// ===== dv/adler32_digest_checker.sv =====
`timescale 1ns / 1ps
// Watches the stream and result channels of the Adler-32 unit, folds every accepted word into
// its own copy of the two running sums and checks each digest in order.
// Depends on adler32_pkg, adler32_in_if and adler32_out_if.

module adler32_digest_checker
    import adler32_pkg::*;
#(
    parameter int unsigned LANES = DEFAULT_LANES
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    adler32_in_if             stream,
    adler32_out_if            result,
    output int unsigned       outstanding,
    output int unsigned       mismatches
);

    localparam int unsigned MAX_REPORTS = 10;

    // Predicted block state
    logic [SUM_W-1:0] start_val;
    logic [SUM_W-1:0] run_low;
    logic [SUM_W-1:0] run_high;
    logic [31:0]      digest_q[$];
    int unsigned      err_cnt = 0;

    // Add the valid bytes of one word, lowest byte first, to both sums
    function automatic void fold_word(input logic [31:0] data, input logic [COUNT_W-1:0] cnt);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned i;
        n = cnt;
        if (n > LANES)
            n = LANES;
        if (n > WORD_BYTES)
            n = WORD_BYTES;
        lo = run_low;
        hi = run_high;
        for (i = 0; i < n; i++)
        begin
            lo = lo + data[8*i +: 8];
            if (lo >= ADLER_MOD)
                lo = lo - ADLER_MOD;
            hi = hi + lo;
            if (hi >= ADLER_MOD)
                hi = hi - ADLER_MOD;
        end
        run_low  = lo[SUM_W-1:0];
        run_high = hi[SUM_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            start_val = 16'd1;
            run_low   = 16'd1;
            run_high  = '0;
            digest_q.delete();
            outstanding <= 0;
        end
        else
        begin
            // Digest transaction: compare against the oldest prediction
            if (result.valid && result.ready)
            begin
                if (digest_q.size() == 0)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: unexpected digest %08h", $realtime, result.digest);
                    err_cnt++;
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (want !== result.digest)
                    begin
                        if (err_cnt < MAX_REPORTS)
                            $display("%0t: digest mismatch: expected %08h (high %04h low %04h), got %08h",
                                     $realtime, want, want[31:16], want[15:0], result.digest);
                        err_cnt++;
                    end
                end
            end

            // Start value only matters at the next reload
            if (cfg_wr_en)
                start_val = cfg_wr_data;

            // Word transaction: fold bytes, close the message on last
            if (stream.valid && stream.ready)
            begin
                fold_word(stream.data_bytes, stream.byte_count);
                if (stream.last)
                begin
                    digest_q.push_back({run_high, run_low});
                    run_low  = start_val;
                    run_high = '0;
                end
            end

            outstanding <= digest_q.size();
        end
        mismatches <= err_cnt;
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the Adler-32 unit testbench: clock, reset, word and config stimulus, result-side
// backpressure and the verdict. Depends on the RTL and adler32_digest_checker.

module testbench;
    import adler32_pkg::*;

    localparam int unsigned STALL_LIMIT      = 4000;
    localparam int unsigned SINK_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES    = 4;
    localparam int unsigned DRAIN_CYCLES     = 10;
    localparam int unsigned RANDOM_WORDS     = 1300;
    localparam int unsigned PHASE_WORDS      = 220;
    localparam logic [15:0] START_STD        = 16'd1;
    localparam logic [15:0] START_TOP        = 16'(ADLER_MOD - 1);

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    int unsigned outstanding;
    int unsigned mismatches;
    int unsigned quiet_cycles = 0;
    int unsigned words_sent = 0;
    int unsigned idle_pct = 0;
    bit          sink_hold = 1'b0;

    adler32_in_if  stream_if ();
    adler32_out_if result_if ();

    adler32_checksum_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (stream_if),
        .result      (result_if)
    );

    adler32_digest_checker digest_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .stream      (stream_if),
        .result      (result_if),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // No gap unless idle_pct picks one; then mostly a short one, rarely a long one
    function automatic int unsigned pick_gap();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 8);
        return $urandom_range(3, 1);
    endfunction

    // Full words dominate; the rest covers short, empty and oversized counts
    function automatic logic [COUNT_W-1:0] pick_count();
        if ($urandom_range(99) < 85)
            return COUNT_W'(WORD_BYTES);
        return COUNT_W'($urandom_range(7, 0));
    endfunction

    function automatic int unsigned pick_length();
        case ($urandom_range(19))
            0:       return $urandom_range(300, 80);
            1, 2, 3: return $urandom_range(30, 9);
            default: return $urandom_range(8, 1);
        endcase
    endfunction

    function automatic logic [15:0] pick_start();
        case ($urandom_range(4))
            0:       return '0;
            1:       return START_STD;
            2:       return START_TOP;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(ADLER_MOD - 1));
        endcase
    endfunction

    // Offer one word and hold it until the transaction; called on a clock edge
    task automatic send_word(input logic [31:0] data, input logic [COUNT_W-1:0] cnt,
                             input logic lst);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid      <= 1'b1;
        stream_if.data_bytes <= data;
        stream_if.byte_count <= cnt;
        stream_if.last       <= lst;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic send_message(input int unsigned n_words);
        int unsigned w;
        for (w = 0; w < n_words; w++)
            send_word($urandom, pick_count(), w == n_words - 1);
    endtask

    // Quiesce the input and wait out every pending digest before touching the register
    task automatic write_start(input logic [15:0] value);
        stream_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Result side: random ready gaps, plus one long hold on request
    initial
    begin
        int unsigned gap;
        result_if.ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (sink_hold)
            begin
                result_if.ready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap != 0)
                begin
                    result_if.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                result_if.ready <= 1'b1;
                repeat ($urandom_range(8, 1)) @(posedge clk);
            end
        end
    end

    // Watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (stream_if.valid && stream_if.ready) ||
            (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        int unsigned phase;
        int unsigned phase_end;
        stream_if.valid      = 1'b0;
        stream_if.data_bytes = '0;
        stream_if.byte_count = '0;
        stream_if.last       = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, single byte, all counts, extreme data
        idle_pct = 0;
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h0000_0061, 3'd1, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd5, 1'b0);
        send_word(32'hA5A5_A5A5, 3'd6, 1'b0);
        send_word(32'h5A5A_5A5A, 3'd7, 1'b0);
        send_word(32'h0000_0000, 3'd3, 1'b1);
        send_word(32'h1234_5678, 3'd2, 1'b0);
        send_word(32'h8080_8080, 3'd0, 1'b0);
        send_word(32'h0102_0304, 3'd4, 1'b1);

        // Start value zero: the first message after the write still uses the old one
        write_start('0);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h0, 3'd0, 1'b1);

        // Start value above the modulus: reported as is, then wrapped by one byte
        write_start(16'hFFFF);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'h0, 3'd1, 1'b1);

        // Largest legal start with full bytes
        write_start(START_TOP);
        send_word(32'h0, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);

        // Register write in the middle of a message leaves the running sums alone
        send_word(32'h1122_3344, 3'd4, 1'b0);
        write_start(START_STD);
        send_word(32'h5566_7788, 3'd4, 1'b1);
        send_word(32'h9900_AABB, 3'd4, 1'b1);

        // Random phases with changing start value and idle rate
        phase = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            write_start(pick_start());
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 25;
                default: idle_pct = 60;
            endcase
            if (phase == 2)
            begin
                // Back-to-back short messages against a stalled result side
                idle_pct  = 0;
                sink_hold = 1'b1;
                repeat (40) send_message(1);
            end
            phase_end = words_sent + PHASE_WORDS;
            if (phase_end > RANDOM_WORDS)
                phase_end = RANDOM_WORDS;
            while (words_sent < phase_end)
                send_message(pick_length());
            phase++;
        end

        // Drain
        stream_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
